### sv/balance_state_feedback_controller_macros.svh
// Assertion macros for the balance controller checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef BALANCE_STATE_FEEDBACK_CONTROLLER_MACROS_SVH
`define BALANCE_STATE_FEEDBACK_CONTROLLER_MACROS_SVH

// same-cycle implication
`define BSFC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/bsfc_pkg.sv
// Shared types and constants of the balance state-feedback controller.
// No dependencies.
`default_nettype none

package bsfc_pkg;

	localparam int unsigned DATA_W          = 32;
	localparam int unsigned MS_W            = 16;
	localparam int unsigned CFG_IDX_W       = 3;
	localparam int unsigned FRAC_BITS_DEF   = 16;
	localparam int unsigned MAX_STEP_MS_DEF = 50;
	localparam int unsigned MS_PER_S        = 1000;
	// x / 1000 == (x * DIV_MUL) >> DIV_SHIFT for any 32-bit unsigned x
	localparam int unsigned DIV_MUL         = 274877907;
	localparam int unsigned DIV_SHIFT       = 38;
	localparam int unsigned MUL_W           = DATA_W + 1;
	localparam int unsigned PROD_W          = 2 * MUL_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PITCH_OFFSET    = 3'd0,
		CFG_OUTPUT_SCALE    = 3'd1,
		CFG_PITCH_GAIN      = 3'd2,
		CFG_PITCH_RATE_GAIN = 3'd3,
		CFG_POSITION_GAIN   = 3'd4,
		CFG_VELOCITY_GAIN   = 3'd5
	} cfg_idx_t;

	localparam logic signed [DATA_W-1:0] RST_PITCH_OFFSET    = 32'sd4588;
	localparam logic signed [DATA_W-1:0] RST_OUTPUT_SCALE    = 32'sd65536;
	localparam logic signed [DATA_W-1:0] RST_PITCH_GAIN      = -32'sd999293;
	localparam logic signed [DATA_W-1:0] RST_PITCH_RATE_GAIN = -32'sd88736;
	localparam logic signed [DATA_W-1:0] RST_POSITION_GAIN   = -32'sd218431;
	localparam logic signed [DATA_W-1:0] RST_VELOCITY_GAIN   = -32'sd263258;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VMS,
		ST_RND,
		ST_DIV,
		ST_INTEG,
		ST_G0,
		ST_G1,
		ST_G2,
		ST_G3,
		ST_G4,
		ST_DRV,
		ST_SCL,
		ST_MIX,
		ST_WB
	} state_t;

endpackage

`default_nettype wire

### sv/bsfc_in_if.sv
// Input channel of the balance controller: one control step per beat.
// Depends on bsfc_pkg.
`default_nettype none

interface bsfc_in_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   enable;
	logic signed [bsfc_pkg::DATA_W-1:0]     pitch;
	logic signed [bsfc_pkg::DATA_W-1:0]     pitch_rate;
	logic signed [bsfc_pkg::DATA_W-1:0]     forward_velocity;
	logic signed [bsfc_pkg::DATA_W-1:0]     target_velocity;
	logic signed [bsfc_pkg::DATA_W-1:0]     turn_velocity;
	logic        [bsfc_pkg::MS_W-1:0]       elapsed_ms;

	modport source (
		output valid, enable, pitch, pitch_rate, forward_velocity,
		       target_velocity, turn_velocity, elapsed_ms,
		input  ready
	);
	modport sink (
		input  valid, enable, pitch, pitch_rate, forward_velocity,
		       target_velocity, turn_velocity, elapsed_ms,
		output ready
	);
endinterface

`default_nettype wire

### sv/bsfc_out_if.sv
// Output channel of the balance controller: one wheel command per beat.
// Depends on bsfc_pkg.
`default_nettype none

interface bsfc_out_if;
	logic                               valid;
	logic                               ready;
	logic                               wheels_enabled;
	logic signed [bsfc_pkg::DATA_W-1:0] left_velocity;
	logic signed [bsfc_pkg::DATA_W-1:0] right_velocity;

	modport source (
		output valid, wheels_enabled, left_velocity, right_velocity,
		input  ready
	);
	modport sink (
		input  valid, wheels_enabled, left_velocity, right_velocity,
		output ready
	);
endinterface

`default_nettype wire

### sv/balance_state_feedback_controller.sv
// Balance state-feedback controller, top level: sequencer around one shared
// 33x33 signed multiplier. Depends on bsfc_pkg, bsfc_in_if, bsfc_out_if.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------------
//   in_ch    | in  | valid/ready        | enable, pitch, pitch_rate, forward_velocity,
//            |     |                    | target_velocity, turn_velocity, elapsed_ms
//   out_ch   | out | valid/ready        | wheels_enabled, left_velocity, right_velocity
//   cfg      | in  | cfg_wen            | cfg_index, cfg_wdata
//
// An enabled step passes ST_VMS through ST_MIX and then loads the result register in ST_WB;
// a disabled one goes straight to ST_WB. No new beat is taken until the step is through.
// Seven products go one after another through the single multiplier.
// in_ch.ready is high only while the sequencer idles; it comes back while a finished
// result still waits in the output register, and the step after that holds in its
// last state until the output register frees. Reset is asynchronous and loads the
// register defaults and a zero integrator.
`default_nettype none

module balance_state_feedback_controller #(
	parameter int unsigned FRAC_BITS   = bsfc_pkg::FRAC_BITS_DEF,
	parameter int unsigned MAX_STEP_MS = bsfc_pkg::MAX_STEP_MS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wen,
	input  wire logic [bsfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bsfc_pkg::DATA_W-1:0]      cfg_wdata,
	bsfc_in_if.sink                               in_ch,
	bsfc_out_if.source                            out_ch
);

	localparam int DW     = bsfc_pkg::DATA_W;
	localparam int MW     = bsfc_pkg::MUL_W;
	localparam int PW     = bsfc_pkg::PROD_W;
	localparam int MSW    = $clog2(MAX_STEP_MS + 1);
	localparam int MAG_W  = DW + MSW;
	localparam int SR_W   = PW - FRAC_BITS;
	localparam int ACC_W  = SR_W + 3;
	localparam longint LIMIT  = ((longint'(1) << FRAC_BITS) + 5) / 10;
	localparam longint INC_SAT = 2 * LIMIT + 1;
	localparam int INC_W  = $clog2(INC_SAT + 1);
	localparam longint THRESH = longint'(bsfc_pkg::MS_PER_S) * INC_SAT;

	localparam logic signed [DW-1:0]  SAT_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0]  SAT_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [PW-1:0]  HALF    = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
	localparam logic signed [DW+1:0]  LIM_P   = (DW+2)'(LIMIT);
	localparam logic signed [DW+1:0]  LIM_N   = -LIM_P;

	function automatic logic signed [DW-1:0] sat33(input logic signed [DW:0] v);
		if (v[DW] == v[DW-1])
			return v[DW-1:0];
		return v[DW] ? SAT_MIN : SAT_MAX;
	endfunction

	function automatic logic signed [DW-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-DW:0] hi;
		hi = v[ACC_W-1:DW-1];
		if (&hi || ~|hi)
			return v[DW-1:0];
		return v[ACC_W-1] ? SAT_MIN : SAT_MAX;
	endfunction

	// floor((p + half) / 2^FRAC_BITS)
	function automatic logic signed [SR_W-1:0] shift_round(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = p + HALF;
		return t[PW-1:FRAC_BITS];
	endfunction

	bsfc_pkg::state_t state_q, state_d;

	logic signed [DW-1:0] pitch_offset_q, output_scale_q, pitch_gain_q;
	logic signed [DW-1:0] pitch_rate_gain_q, position_gain_q, velocity_gain_q;
	logic signed [DW-1:0] pos_q;

	logic                 en_q;
	logic signed [DW-1:0] perr_q, verr_q, rate_q, turn_q, drive_q;
	logic [MSW-1:0]       ms_q;
	logic [DW-1:0]        rnd_q;
	logic                 big_q, neg_q;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q;

	logic                 out_valid_q, out_en_q;
	logic signed [DW-1:0] out_left_q, out_right_q;

	logic in_beat, slot_free, load_out;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_offset_q    <= bsfc_pkg::RST_PITCH_OFFSET;
			output_scale_q    <= bsfc_pkg::RST_OUTPUT_SCALE;
			pitch_gain_q      <= bsfc_pkg::RST_PITCH_GAIN;
			pitch_rate_gain_q <= bsfc_pkg::RST_PITCH_RATE_GAIN;
			position_gain_q   <= bsfc_pkg::RST_POSITION_GAIN;
			velocity_gain_q   <= bsfc_pkg::RST_VELOCITY_GAIN;
		end else if (cfg_wen) begin
			unique case (bsfc_pkg::cfg_idx_t'(cfg_index))
				bsfc_pkg::CFG_PITCH_OFFSET:    pitch_offset_q    <= cfg_wdata;
				bsfc_pkg::CFG_OUTPUT_SCALE:    output_scale_q    <= cfg_wdata;
				bsfc_pkg::CFG_PITCH_GAIN:      pitch_gain_q      <= cfg_wdata;
				bsfc_pkg::CFG_PITCH_RATE_GAIN: pitch_rate_gain_q <= cfg_wdata;
				bsfc_pkg::CFG_POSITION_GAIN:   position_gain_q   <= cfg_wdata;
				bsfc_pkg::CFG_VELOCITY_GAIN:   velocity_gain_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bsfc_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsfc_pkg::ST_IDLE: begin
				if (in_ch.valid)
					state_d = in_ch.enable ? bsfc_pkg::ST_VMS : bsfc_pkg::ST_WB;
			end
			bsfc_pkg::ST_VMS:   state_d = bsfc_pkg::ST_RND;
			bsfc_pkg::ST_RND:   state_d = bsfc_pkg::ST_DIV;
			bsfc_pkg::ST_DIV:   state_d = bsfc_pkg::ST_INTEG;
			bsfc_pkg::ST_INTEG: state_d = bsfc_pkg::ST_G0;
			bsfc_pkg::ST_G0:    state_d = bsfc_pkg::ST_G1;
			bsfc_pkg::ST_G1:    state_d = bsfc_pkg::ST_G2;
			bsfc_pkg::ST_G2:    state_d = bsfc_pkg::ST_G3;
			bsfc_pkg::ST_G3:    state_d = bsfc_pkg::ST_G4;
			bsfc_pkg::ST_G4:    state_d = bsfc_pkg::ST_DRV;
			bsfc_pkg::ST_DRV:   state_d = bsfc_pkg::ST_SCL;
			bsfc_pkg::ST_SCL:   state_d = bsfc_pkg::ST_MIX;
			bsfc_pkg::ST_MIX:   state_d = bsfc_pkg::ST_WB;
			bsfc_pkg::ST_WB: begin
				if (slot_free)
					state_d = bsfc_pkg::ST_IDLE;
			end
			default:            state_d = bsfc_pkg::ST_IDLE;
		endcase
	end

	assign slot_free = !out_valid_q || out_ch.ready;

	// control outputs and multiplier operand select
	always_comb begin
		in_ch.ready = 1'b0;
		load_out    = 1'b0;
		mul_a       = '0;
		mul_b       = '0;
		unique case (state_q)
			bsfc_pkg::ST_IDLE: in_ch.ready = 1'b1;
			bsfc_pkg::ST_VMS: begin
				mul_a = (MW)'(verr_q);
				mul_b = (MW)'(ms_q);
			end
			bsfc_pkg::ST_DIV: begin
				mul_a = (MW)'(rnd_q);
				mul_b = (MW)'(bsfc_pkg::DIV_MUL);
			end
			bsfc_pkg::ST_G0: begin
				mul_a = (MW)'(pitch_gain_q);
				mul_b = (MW)'(perr_q);
			end
			bsfc_pkg::ST_G1: begin
				mul_a = (MW)'(pitch_rate_gain_q);
				mul_b = (MW)'(rate_q);
			end
			bsfc_pkg::ST_G2: begin
				mul_a = (MW)'(position_gain_q);
				mul_b = (MW)'(pos_q);
			end
			bsfc_pkg::ST_G3: begin
				mul_a = (MW)'(velocity_gain_q);
				mul_b = (MW)'(verr_q);
			end
			bsfc_pkg::ST_SCL: begin
				mul_a = (MW)'(drive_q);
				mul_b = (MW)'(output_scale_q);
			end
			bsfc_pkg::ST_WB: load_out = slot_free;
			default: ;
		endcase
	end

	assign in_beat = in_ch.valid && in_ch.ready;

	// ---------------- datapath ----------------
	logic [MAG_W-1:0]       mag, mag_rnd;
	logic [INC_W-1:0]       inc;
	logic signed [DW+1:0]   pos_sum;
	logic signed [ACC_W-1:0] sr_ext;

	always_comb begin
		mag     = prod_q[PW-1] ? (MAG_W)'(-prod_q) : (MAG_W)'(prod_q);
		mag_rnd = mag + (MAG_W)'(bsfc_pkg::MS_PER_S / 2);
		inc     = big_q ? (INC_W)'(INC_SAT) : prod_q[bsfc_pkg::DIV_SHIFT +: INC_W];
		pos_sum = neg_q ? (DW+2)'(pos_q) - (DW+2)'(inc) : (DW+2)'(pos_q) + (DW+2)'(inc);
		sr_ext  = (ACC_W)'(shift_round(prod_q));
	end

	always_ff @(posedge clk)
		prod_q <= mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pos_q <= '0;
		else if (in_beat && !in_ch.enable)
			pos_q <= '0;
		else if (state_q == bsfc_pkg::ST_INTEG) begin
			if (pos_sum > LIM_P)
				pos_q <= LIM_P[DW-1:0];
			else if (pos_sum < LIM_N)
				pos_q <= LIM_N[DW-1:0];
			else
				pos_q <= pos_sum[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			en_q   <= in_ch.enable;
			perr_q <= sat33((DW+1)'(in_ch.pitch) - (DW+1)'(pitch_offset_q));
			verr_q <= sat33((DW+1)'(in_ch.forward_velocity)
			                - (DW+1)'(in_ch.target_velocity));
			rate_q <= in_ch.pitch_rate;
			turn_q <= in_ch.turn_velocity;
			if (in_ch.elapsed_ms > (bsfc_pkg::MS_W)'(MAX_STEP_MS))
				ms_q <= (MSW)'(MAX_STEP_MS);
			else
				ms_q <= in_ch.elapsed_ms[MSW-1:0];
		end
		case (state_q)
			bsfc_pkg::ST_RND: begin
				neg_q <= prod_q[PW-1];
				big_q <= mag_rnd >= (MAG_W)'(THRESH);
				rnd_q <= mag_rnd[DW-1:0];
			end
			bsfc_pkg::ST_G1:  acc_q <= sr_ext;
			bsfc_pkg::ST_G2,
			bsfc_pkg::ST_G3,
			bsfc_pkg::ST_G4:  acc_q <= acc_q + sr_ext;
			bsfc_pkg::ST_DRV: drive_q <= sat_acc(-acc_q);
			bsfc_pkg::ST_MIX: acc_q <= sr_ext;
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_en_q <= en_q;
			if (en_q) begin
				out_left_q  <= sat_acc(acc_q + (ACC_W)'(turn_q));
				out_right_q <= sat_acc(acc_q - (ACC_W)'(turn_q));
			end else begin
				out_left_q  <= '0;
				out_right_q <= '0;
			end
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.wheels_enabled = out_en_q;
	assign out_ch.left_velocity  = out_left_q;
	assign out_ch.right_velocity = out_right_q;

endmodule

`default_nettype wire

### sv/bsfc_checker.sv
// Port-level checks of the balance controller, bound into the top level.
// Depends on balance_state_feedback_controller_macros.svh and bsfc_pkg.
`default_nettype none
`include "balance_state_feedback_controller_macros.svh"

module bsfc_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic                             wheels_enabled,
	input wire logic signed [bsfc_pkg::DATA_W-1:0] left_velocity,
	input wire logic signed [bsfc_pkg::DATA_W-1:0] right_velocity
);

	// a stalled result beat stays offered
	`BSFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")

	// disabled steps carry a zero command
	`BSFC_ASSERT_SAME(a_off_zero, out_valid && !wheels_enabled, left_velocity == '0 && right_velocity == '0, "disabled beat with nonzero command")

	// one step at a time: busy right after an accepted beat
	`BSFC_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "input taken while busy")

endmodule

bind balance_state_feedback_controller bsfc_checker u_bsfc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.wheels_enabled (out_ch.wheels_enabled),
	.left_velocity  (out_ch.left_velocity),
	.right_velocity (out_ch.right_velocity)
);

`default_nettype wire
